// File: rtl/rrat_pkg.sv
// ----------------------------------------------------------------------------
// rrat_pkg
// Shared types and codes of the round robin agent table arbiter: field
// widths, opcodes, status codes, the table entry layout and the compare
// unit request.
// ----------------------------------------------------------------------------
package rrat_pkg;

  localparam int KEY_W    = 16;
  localparam int LOAD_W   = 10;
  localparam int LAT_W    = 32;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 5;
  localparam int OP_W     = 2;

  localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
  localparam logic [OP_W-1:0] OP_SCHEDULE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd4;

  // 900 thousandths
  localparam logic [LOAD_W-1:0] LIMIT_RESET = 10'd900;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              ready;
    logic [LOAD_W-1:0] load;
    logic [LAT_W-1:0]  latency;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              sched;
    logic [KEY_W-1:0]  key;
    logic [LOAD_W-1:0] limit;
  } match_req_t;

endpackage

// File: rtl/rrat_ram.sv
// ----------------------------------------------------------------------------
// rrat_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rrat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rrat_match.sv
// ----------------------------------------------------------------------------
// rrat_match
// Shared compare unit: key equality for register and unregister scans,
// eligibility (available and load below the limit) for schedule scans.
// ----------------------------------------------------------------------------
module rrat_match (
  input  rrat_pkg::match_req_t req,
  input  rrat_pkg::entry_t     ent,
  output logic                 hit
);

  always_comb begin
    if (req.sched) begin
      hit = ent.ready && (ent.load < req.limit);
    end else begin
      hit = (ent.key == req.key);
    end
  end

endmodule

// File: rtl/round_robin_agent_table_arbiter.sv
// ----------------------------------------------------------------------------
// round_robin_agent_table_arbiter
// Compact ordered agent table with register, unregister and round robin
// schedule commands, worked one table entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive opcode, agent_key, agent_ready, agent_load and
//   agent_latency with start high; the word is taken at a clock edge where
//   busy is low. busy stays high until the result has been issued.
//   Result channel: done pulses for one cycle with status, chosen_key,
//   chosen_latency, ready_total and entry_total. The receiver cannot stall;
//   the result fields change only at a done pulse.
//   Timing: one RAM with a read and a write port holds the table, read one
//   entry per cycle, so a command ends soonest on an unused opcode or an
//   empty table and at most after one pass over the table. An unregister
//   scans up to the matching entry and then shifts the later entries down one
//   per cycle, so scan plus shift never exceeds one pass.
//   A new command can be accepted in the cycle done is high.
//   Configuration: APB register 0 (byte address 0) is load_limit, reset 900.
//   Write it only while no command is in flight.
//   Reset: rst clears the entry count, the ready count, the round robin
//   pointer and the sequencer. Table contents are not cleared; only entries
//   below the entry count are ever read.
// ----------------------------------------------------------------------------
module round_robin_agent_table_arbiter #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [rrat_pkg::OP_W-1:0]           opcode,
  input  logic [rrat_pkg::KEY_W-1:0]          agent_key,
  input  logic                                agent_ready,
  input  logic [rrat_pkg::LOAD_W-1:0]         agent_load,
  input  logic [rrat_pkg::LAT_W-1:0]          agent_latency,
  // result channel
  output logic                                done,
  output logic [rrat_pkg::STATUS_W-1:0]       status,
  output logic [rrat_pkg::KEY_W-1:0]          chosen_key,
  output logic [rrat_pkg::LAT_W-1:0]          chosen_latency,
  output logic [rrat_pkg::TOTAL_W-1:0]        ready_total,
  output logic [rrat_pkg::TOTAL_W-1:0]        entry_total,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CK   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_SH   = 3'd3;
  localparam logic [2:0] S_DEL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // control state
  logic [2:0]                    state;
  logic [CW-1:0]                 entry_count;
  logic [CW-1:0]                 ready_count;
  logic [IW-1:0]                 next_pointer;
  logic [rrat_pkg::LOAD_W-1:0]   load_limit;

  // working registers of the current command
  logic [rrat_pkg::OP_W-1:0]     op;
  rrat_pkg::entry_t              cmd;
  logic [IW-1:0]                 idx;
  logic [CW-1:0]                 tries;
  logic [IW-1:0]                 slot;
  logic                          found;
  logic                          old_ready;
  logic [rrat_pkg::STATUS_W-1:0] res_status;
  logic [rrat_pkg::KEY_W-1:0]    res_key;
  logic [rrat_pkg::LAT_W-1:0]    res_latency;

  // table memory
  logic                          mem_we;
  logic [IW-1:0]                 mem_waddr;
  logic [rrat_pkg::ENTRY_W-1:0]  mem_wdata;
  logic [IW-1:0]                 mem_raddr;
  logic [rrat_pkg::ENTRY_W-1:0]  mem_rdata;
  rrat_pkg::entry_t              rd_entry;

  rrat_pkg::match_req_t          mreq;
  logic                          hit;

  // scan arithmetic
  logic [CW-1:0]                 idx_inc;
  logic                          idx_more;
  logic [IW-1:0]                 idx_wrap;
  logic [CW-1:0]                 idx_inc2;
  logic [CW-1:0]                 tries_inc;
  logic [IW-1:0]                 sched_start;
  logic [CW-1:0]                 count_dec;
  logic                          cfg_write;

  assign rd_entry    = rrat_pkg::entry_t'(mem_rdata);
  assign idx_inc     = CW'(idx) + CW'(1);
  assign idx_more    = idx_inc < entry_count;
  assign idx_wrap    = idx_more ? idx_inc[IW-1:0] : '0;
  assign idx_inc2    = CW'(idx) + CW'(2);
  assign tries_inc   = tries + CW'(1);
  assign sched_start = (CW'(next_pointer) < entry_count) ? next_pointer : '0;
  assign count_dec   = entry_count - CW'(1);

  assign busy = (state != S_IDLE);

  // Shared compare unit: key match or eligibility, chosen by the opcode.
  assign mreq.sched = (op == rrat_pkg::OP_SCHEDULE);
  assign mreq.key   = cmd.key;
  assign mreq.limit = load_limit;

  rrat_match u_match (
    .req (mreq),
    .ent (rd_entry),
    .hit (hit)
  );

  rrat_ram #(
    .WIDTH (rrat_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Read address is presented in the cycle before its entry is examined.
  always_comb begin
    case (state)
      S_IDLE: begin
        mem_raddr = (opcode == rrat_pkg::OP_SCHEDULE) ? sched_start : '0;
      end
      S_CK: begin
        if (op == rrat_pkg::OP_UNREGISTER && hit) begin
          // first entry to move down
          mem_raddr = idx_inc[IW-1:0];
        end else begin
          mem_raddr = idx_wrap;
        end
      end
      S_SH: begin
        mem_raddr = idx_inc2[IW-1:0];
      end
      default: begin
        mem_raddr = idx;
      end
    endcase
  end

  // Write either the new/updated entry or the entry shifted down one slot.
  always_comb begin
    mem_we    = (state == S_WR) || (state == S_SH);
    mem_waddr = (state == S_WR) ? slot : idx;
    mem_wdata = (state == S_WR) ? rrat_pkg::ENTRY_W'(cmd) : mem_rdata;
  end

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : {22'd0, load_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= rrat_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      load_limit <= pwdata[rrat_pkg::LOAD_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      ready_count  <= '0;
      next_pointer <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op          <= opcode;
            cmd.key     <= agent_key;
            cmd.ready   <= agent_ready;
            cmd.load    <= agent_load;
            cmd.latency <= agent_latency;
            tries       <= '0;
            res_status  <= rrat_pkg::ST_OK;
            res_key     <= '0;
            res_latency <= '0;
            idx         <= (opcode == rrat_pkg::OP_SCHEDULE) ? sched_start : '0;
            case (opcode)
              rrat_pkg::OP_REGISTER: begin
                if (entry_count == '0) begin
                  // empty table: append at slot zero straight away
                  slot  <= '0;
                  found <= 1'b0;
                  state <= S_WR;
                end else begin
                  state <= S_CK;
                end
              end
              rrat_pkg::OP_UNREGISTER: begin
                if (entry_count == '0) begin
                  res_status <= rrat_pkg::ST_NOT_FOUND;
                  state      <= S_FIN;
                end else begin
                  state <= S_CK;
                end
              end
              rrat_pkg::OP_SCHEDULE: begin
                if (entry_count == '0) begin
                  res_status <= rrat_pkg::ST_EMPTY;
                  state      <= S_FIN;
                end else begin
                  state <= S_CK;
                end
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end

        S_CK: begin
          case (op)
            rrat_pkg::OP_REGISTER: begin
              if (hit) begin
                slot      <= idx;
                found     <= 1'b1;
                old_ready <= rd_entry.ready;
                state     <= S_WR;
              end else if (idx_more) begin
                idx <= idx_wrap;
              end else if (entry_count == CW'(MAX_ENTRIES)) begin
                res_status <= rrat_pkg::ST_FULL;
                state      <= S_FIN;
              end else begin
                slot  <= entry_count[IW-1:0];
                found <= 1'b0;
                state <= S_WR;
              end
            end
            rrat_pkg::OP_UNREGISTER: begin
              if (hit) begin
                ready_count <= ready_count - CW'(rd_entry.ready);
                // hold idx: it is the first slot to overwrite
                state       <= idx_more ? S_SH : S_DEL;
              end else if (idx_more) begin
                idx <= idx_wrap;
              end else begin
                res_status <= rrat_pkg::ST_NOT_FOUND;
                state      <= S_FIN;
              end
            end
            default: begin
              // schedule scan, wrapping round from the start slot
              if (hit) begin
                res_key      <= rd_entry.key;
                res_latency  <= rd_entry.latency;
                next_pointer <= idx_wrap;
                state        <= S_FIN;
              end else if (tries_inc < entry_count) begin
                idx   <= idx_wrap;
                tries <= tries_inc;
              end else begin
                res_status <= rrat_pkg::ST_NONE;
                state      <= S_FIN;
              end
            end
          endcase
        end

        S_WR: begin
          if (found) begin
            ready_count <= ready_count - CW'(old_ready) + CW'(cmd.ready);
          end else begin
            ready_count <= ready_count + CW'(cmd.ready);
            entry_count <= entry_count + CW'(1);
          end
          state <= S_FIN;
        end

        S_SH: begin
          // entry idx+1 is on the read port and lands in slot idx
          if (idx_inc2 < entry_count) begin
            idx <= idx_inc[IW-1:0];
          end else begin
            state <= S_DEL;
          end
        end

        S_DEL: begin
          entry_count <= count_dec;
          if (CW'(next_pointer) >= count_dec && count_dec != '0) begin
            next_pointer <= '0;
          end
          state <= S_FIN;
        end

        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word, issued together with the done pulse
  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      status         <= res_status;
      chosen_key     <= res_key;
      chosen_latency <= res_latency;
      ready_total    <= rrat_pkg::TOTAL_W'(ready_count);
      entry_total    <= rrat_pkg::TOTAL_W'(entry_count);
    end
  end

endmodule

// File: tb/sv/round_robin_agent_table_arbiter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_agent_table_arbiter_test
// Self-checking bench for the agent table arbiter. A short directed script
// walks the empty, full-range and error cases; random phases then fill,
// churn and drain the table under several load limits. Every command word
// is predicted by an in-bench model of the table and the round robin
// pointer, and every done pulse is checked field by field against it or a pinned result.
// ----------------------------------------------------------------------------
module round_robin_agent_table_arbiter_test;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_POOL_N  = 24;   // more keys than slots, so the table fills
  localparam int DRAIN_LIMIT = 1000; // cycles allowed for the last results

  // no opcode 3 in the package; the block must treat it as a no-op
  localparam logic [rrat_pkg::OP_W-1:0] OP_UNUSED  = 2'd3;
  localparam logic [2:0]                LIMIT_ADDR = 3'd0;

  // one command word as driven on the command channel
  typedef struct packed {
    logic [rrat_pkg::OP_W-1:0]   op;
    logic [rrat_pkg::KEY_W-1:0]  key;
    logic                        ready;
    logic [rrat_pkg::LOAD_W-1:0] load;
    logic [rrat_pkg::LAT_W-1:0]  latency;
  } word_t;

  // one arbitration result as seen on the result channel
  typedef struct packed {
    logic [rrat_pkg::STATUS_W-1:0] status;
    logic [rrat_pkg::KEY_W-1:0]    key;
    logic [rrat_pkg::LAT_W-1:0]    latency;
    logic [rrat_pkg::TOTAL_W-1:0]  ready_total;
    logic [rrat_pkg::TOTAL_W-1:0]  entry_total;
  } pick_t;

  // directed script row; pinned rows carry a hand-written result
  typedef struct {
    word_t w;
    bit    pinned;
    pick_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          start         = 1'b0;
  logic [rrat_pkg::OP_W-1:0]     opcode        = '0;
  logic [rrat_pkg::KEY_W-1:0]    agent_key     = '0;
  logic                          agent_ready   = 1'b0;
  logic [rrat_pkg::LOAD_W-1:0]   agent_load    = '0;
  logic [rrat_pkg::LAT_W-1:0]    agent_latency = '0;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [2:0]                    paddr         = '0;
  logic [31:0]                   pwdata        = '0;

  logic                          busy;
  logic                          done;
  logic [rrat_pkg::STATUS_W-1:0] status;
  logic [rrat_pkg::KEY_W-1:0]    chosen_key;
  logic [rrat_pkg::LAT_W-1:0]    chosen_latency;
  logic [rrat_pkg::TOTAL_W-1:0]  ready_total;
  logic [rrat_pkg::TOTAL_W-1:0]  entry_total;
  logic [31:0]                   prdata;
  logic                          pready;

  round_robin_agent_table_arbiter #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .opcode(opcode), .agent_key(agent_key), .agent_ready(agent_ready),
    .agent_load(agent_load), .agent_latency(agent_latency),
    .done(done), .status(status), .chosen_key(chosen_key),
    .chosen_latency(chosen_latency), .ready_total(ready_total),
    .entry_total(entry_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run (every word waiting out a
  // long gap plus a full table pass).
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Table model: compact ordered agent list, round robin pointer, load limit
  // --------------------------------------------------------------------------
  rrat_pkg::entry_t            agents [MAX_ENTRIES];
  int                          n_agents   = 0;
  int                          rr_ptr     = 0;
  logic [rrat_pkg::LOAD_W-1:0] load_limit = rrat_pkg::LIMIT_RESET;

  pick_t                       pending [$];   // predicted results, oldest first
  row_t                        script  [$];
  logic [rrat_pkg::KEY_W-1:0]  key_pool [KEY_POOL_N];
  int                          errors = 0;

  // Return the slot holding key, or -1 when the key is not in the table.
  function automatic int find_slot(input logic [rrat_pkg::KEY_W-1:0] key);
    int slot;
    slot = -1;
    for (int i = n_agents - 1; i >= 0; i--)
      if (agents[i].key == key) slot = i;
    return slot;
  endfunction

  // Apply one command word to the model and return the result it causes.
  function automatic pick_t arbitrate(input word_t w);
    pick_t r;
    int    slot;
    int    idx;
    int    n_ready;
    bit    found;
    r = '0;
    r.status = rrat_pkg::ST_OK;
    case (w.op)
      rrat_pkg::OP_REGISTER: begin
        // existing key wins over the full check: update in place
        slot = find_slot(w.key);
        if (slot < 0) begin
          if (n_agents >= MAX_ENTRIES) begin
            r.status = rrat_pkg::ST_FULL;
          end else begin
            slot = n_agents;
            n_agents++;
          end
        end
        if (r.status == rrat_pkg::ST_OK) begin
          agents[slot].key     = w.key;
          agents[slot].ready   = w.ready;
          agents[slot].load    = w.load;
          agents[slot].latency = w.latency;
        end
      end
      rrat_pkg::OP_UNREGISTER: begin
        slot = find_slot(w.key);
        if (slot < 0) begin
          r.status = rrat_pkg::ST_NOT_FOUND;
        end else begin
          for (int j = slot; j + 1 < n_agents; j++) agents[j] = agents[j + 1];
          n_agents--;
          // wrap only while entries remain; an emptied table keeps the pointer
          if (rr_ptr >= n_agents && n_agents > 0) rr_ptr = 0;
        end
      end
      rrat_pkg::OP_SCHEDULE: begin
        if (n_agents == 0) begin
          r.status = rrat_pkg::ST_EMPTY;
        end else begin
          idx   = (rr_ptr < n_agents) ? rr_ptr : 0;
          found = 1'b0;
          r.status = rrat_pkg::ST_NONE;
          for (int t = 0; t < n_agents && !found; t++) begin
            if (agents[idx].ready && agents[idx].load < load_limit) begin
              found     = 1'b1;
              r.status  = rrat_pkg::ST_OK;
              r.key     = agents[idx].key;
              r.latency = agents[idx].latency;
              rr_ptr    = (idx + 1 < n_agents) ? idx + 1 : 0;
            end else begin
              idx = (idx + 1 < n_agents) ? idx + 1 : 0;
            end
          end
        end
      end
      default: ;
    endcase
    n_ready = 0;
    for (int i = 0; i < n_agents; i++) n_ready += agents[i].ready;
    r.ready_total = n_ready[rrat_pkg::TOTAL_W-1:0];
    r.entry_total = n_agents[rrat_pkg::TOTAL_W-1:0];
    return r;
  endfunction

  function automatic word_t word(input logic [rrat_pkg::OP_W-1:0] op,
                                 input logic [rrat_pkg::KEY_W-1:0] key,
                                 input logic ready,
                                 input logic [rrat_pkg::LOAD_W-1:0] load,
                                 input logic [rrat_pkg::LAT_W-1:0] latency);
    word_t w;
    w.op = op; w.key = key; w.ready = ready; w.load = load; w.latency = latency;
    return w;
  endfunction

  function automatic pick_t pick(input logic [rrat_pkg::STATUS_W-1:0] st,
                                 input logic [rrat_pkg::KEY_W-1:0] key,
                                 input logic [rrat_pkg::LAT_W-1:0] latency,
                                 input logic [rrat_pkg::TOTAL_W-1:0] n_ready,
                                 input logic [rrat_pkg::TOTAL_W-1:0] n_entries);
    pick_t p;
    p.status = st; p.key = key; p.latency = latency;
    p.ready_total = n_ready; p.entry_total = n_entries;
    return p;
  endfunction

  function automatic void add_row(input word_t w);
    row_t r;
    r.w = w; r.pinned = 1'b0; r.want = '0;
    script.push_back(r);
  endfunction

  function automatic void add_pinned(input word_t w, input pick_t want);
    row_t r;
    r.w = w; r.pinned = 1'b1; r.want = want;
    script.push_back(r);
  endfunction

  // Pick a load that lands on, just under, or far from the current limit.
  function automatic logic [rrat_pkg::LOAD_W-1:0] near_limit_load();
    case ($urandom_range(0, 4))
      0:       return load_limit;
      1:       return (load_limit == 0) ? '0 : load_limit - 1'b1;
      2:       return '0;
      3:       return '1;
      default: return rrat_pkg::LOAD_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Random command word: mostly well-formed traffic on the key pool, with a
  // little noise (unused opcode, keys outside the pool).
  function automatic word_t random_word(input int reg_pct, input int unreg_pct);
    word_t w;
    int    roll;
    w.key     = rrat_pkg::KEY_W'($urandom);
    w.ready   = 1'($urandom_range(0, 1));
    w.load    = rrat_pkg::LOAD_W'($urandom_range(0, 1023));
    w.latency = $urandom;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 5) begin
      w.op = rrat_pkg::OP_W'($urandom_range(0, 3));
    end else if (roll < reg_pct) begin
      w.op    = rrat_pkg::OP_REGISTER;
      w.key   = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
      w.ready = ($urandom_range(0, 3) != 0);
      w.load  = near_limit_load();
    end else if (roll < reg_pct + unreg_pct) begin
      w.op = rrat_pkg::OP_UNREGISTER;
      if ($urandom_range(0, 99) < 85) w.key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    end else begin
      w.op = rrat_pkg::OP_SCHEDULE;
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic complain(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    errors++;
  endtask

  // Compare each done pulse with the oldest prediction.
  always @(posedge clk) begin : check_result
    pick_t want;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        complain("unexpected result (status)", '0, 32'(status));
      end else begin
        want = pending.pop_front();
        if (status !== want.status) complain("status", 32'(want.status), 32'(status));
        if (chosen_key !== want.key) complain("chosen_key", 32'(want.key), 32'(chosen_key));
        if (chosen_latency !== want.latency)
          complain("chosen_latency", want.latency, chosen_latency);
        if (ready_total !== want.ready_total)
          complain("ready_total", 32'(want.ready_total), 32'(ready_total));
        if (entry_total !== want.entry_total)
          complain("entry_total", 32'(want.entry_total), 32'(entry_total));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Present one word and hold it until taken (start high, busy low at an
  // edge); then advance the model. start is left high for a back-to-back word.
  task automatic send(input word_t w, input bit pinned, input pick_t want);
    pick_t predicted;
    opcode        <= w.op;
    agent_key     <= w.key;
    agent_ready   <= w.ready;
    agent_load    <= w.load;
    agent_latency <= w.latency;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = arbitrate(w);
    pending.push_back(pinned ? want : predicted);
  endtask

  // Idle the command side: mostly no gap or a short one, now and then long.
  task automatic idle_gap(input bit gaps_on);
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    n = 0;
    if (gaps_on) begin
      if (roll >= 90)      n = $urandom_range(8, 40);
      else if (roll >= 55) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // One APB transfer to the load limit register: setup, then access until
  // pready; psel and penable then drop before the next transfer starts.
  task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LIMIT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write the limit, read it back, and track it in the model.
  task automatic set_load_limit(input logic [rrat_pkg::LOAD_W-1:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, {22'd0, value}, rd);
    apb_xfer(1'b0, 32'd0, rd);
    if (rd !== {22'd0, value}) complain("load_limit readback", {22'd0, value}, rd);
    load_limit = value;
  endtask

  // Hold off until every issued word has produced its result.
  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int n_items;
    int reg_pct;
    int unreg_pct;
    bit gaps_on;
    int waited;

    // key pool: both extreme keys plus random ones
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = rrat_pkg::KEY_W'($urandom);

    // Directed script at the reset limit of 900. Pinned rows have an obvious
    // result: empty table, unknown key, unused opcode, counts after plain
    // appends, the first pick from entry 0, no eligible agent, last removal.
    add_pinned(word(rrat_pkg::OP_SCHEDULE, 16'h0000, 1'b0, 10'd0, 32'h0),
               pick(rrat_pkg::ST_EMPTY, 16'h0, 32'h0, 5'd0, 5'd0));
    add_pinned(word(rrat_pkg::OP_UNREGISTER, 16'h1234, 1'b1, 10'd0, 32'h0),
               pick(rrat_pkg::ST_NOT_FOUND, 16'h0, 32'h0, 5'd0, 5'd0));
    add_pinned(word(OP_UNUSED, 16'hFFFF, 1'b1, 10'h3FF, 32'hFFFF_FFFF),
               pick(rrat_pkg::ST_OK, 16'h0, 32'h0, 5'd0, 5'd0));
    add_pinned(word(rrat_pkg::OP_REGISTER, 16'h0000, 1'b1, 10'd0, 32'h0),
               pick(rrat_pkg::ST_OK, 16'h0, 32'h0, 5'd1, 5'd1));
    add_pinned(word(rrat_pkg::OP_REGISTER, 16'hFFFF, 1'b1, 10'h3FF, 32'hFFFF_FFFF),
               pick(rrat_pkg::ST_OK, 16'h0, 32'h0, 5'd2, 5'd2));
    add_pinned(word(rrat_pkg::OP_REGISTER, 16'h00A5, 1'b0, 10'd899, 32'h1234_5678),
               pick(rrat_pkg::ST_OK, 16'h0, 32'h0, 5'd2, 5'd3));
    add_pinned(word(rrat_pkg::OP_SCHEDULE, 16'h0000, 1'b0, 10'd0, 32'h0),
               pick(rrat_pkg::ST_OK, 16'h0000, 32'h0, 5'd2, 5'd3));
    // saturated load and a not-ready entry are skipped, the scan wraps
    add_row(word(rrat_pkg::OP_SCHEDULE, 16'hFFFF, 1'b1, 10'h3FF, 32'hFFFF_FFFF));
    // update in place: becomes ready, load one under the limit
    add_row(word(rrat_pkg::OP_REGISTER, 16'h00A5, 1'b1, 10'd899, 32'hDEAD_BEEF));
    add_row(word(rrat_pkg::OP_SCHEDULE, 16'h0000, 1'b0, 10'd0, 32'h0));
    // load equal to the limit is not eligible
    add_row(word(rrat_pkg::OP_REGISTER, 16'h5A5A, 1'b1, 10'd900, 32'h0000_0001));
    add_row(word(rrat_pkg::OP_REGISTER, 16'h0000, 1'b0, 10'd0, 32'h0));
    add_row(word(rrat_pkg::OP_SCHEDULE, 16'h0000, 1'b0, 10'd0, 32'h0));
    // drop the last entry with the pointer on it: pointer wraps to 0
    add_row(word(rrat_pkg::OP_UNREGISTER, 16'h5A5A, 1'b0, 10'd0, 32'h0));
    add_row(word(rrat_pkg::OP_SCHEDULE, 16'h0000, 1'b0, 10'd0, 32'h0));
    // remove from the middle and the front, shifting later entries down
    add_row(word(rrat_pkg::OP_UNREGISTER, 16'hFFFF, 1'b0, 10'd0, 32'h0));
    add_row(word(rrat_pkg::OP_UNREGISTER, 16'h0000, 1'b0, 10'd0, 32'h0));
    add_row(word(rrat_pkg::OP_SCHEDULE, 16'h0000, 1'b0, 10'd0, 32'h0));
    add_row(word(rrat_pkg::OP_REGISTER, 16'h00A5, 1'b0, 10'd5, 32'h0000_00FF));
    add_pinned(word(rrat_pkg::OP_SCHEDULE, 16'h0000, 1'b0, 10'd0, 32'h0),
               pick(rrat_pkg::ST_NONE, 16'h0, 32'h0, 5'd0, 5'd1));
    add_pinned(word(rrat_pkg::OP_UNREGISTER, 16'h00A5, 1'b0, 10'd0, 32'h0),
               pick(rrat_pkg::ST_OK, 16'h0, 32'h0, 5'd0, 5'd0));
    add_pinned(word(rrat_pkg::OP_SCHEDULE, 16'h0000, 1'b0, 10'd0, 32'h0),
               pick(rrat_pkg::ST_EMPTY, 16'h0, 32'h0, 5'd0, 5'd0));
    add_pinned(word(rrat_pkg::OP_UNREGISTER, 16'h00A5, 1'b0, 10'd0, 32'h0),
               pick(rrat_pkg::ST_NOT_FOUND, 16'h0, 32'h0, 5'd0, 5'd0));

    // hold reset, release it, and wait before the first word
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      send(script[i].w, script[i].pinned, script[i].want);
      if (i == script.size() - 1) start <= 1'b0;
      else idle_gap(1'b1);
    end
    drain();

    // Random phases. Each sets the limit (phase 0 keeps the reset value),
    // a traffic mix that fills, churns or drains the table, and whether
    // the command side idles at all.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin reg_pct = 70; unreg_pct = 10; gaps_on = 1'b1; n_items = 150; end
        1: begin reg_pct = 45; unreg_pct = 20; gaps_on = 1'b0; n_items = 150;
                 set_load_limit(10'h3FF); end
        2: begin reg_pct = 40; unreg_pct = 25; gaps_on = 1'b1; n_items = 100;
                 set_load_limit(10'd0); end
        3: begin reg_pct = 70; unreg_pct = 10; gaps_on = 1'b1; n_items = 100;
                 set_load_limit(10'd1); end
        4: begin reg_pct = 25; unreg_pct = 45; gaps_on = 1'b1; n_items = 150;
                 set_load_limit(rrat_pkg::LOAD_W'($urandom_range(2, 1022))); end
        5: begin reg_pct = 40; unreg_pct = 20; gaps_on = 1'b0; n_items = 100;
                 set_load_limit(10'd512); end
        default: begin reg_pct = 40; unreg_pct = 25; gaps_on = 1'b1; n_items = 100;
                 set_load_limit(rrat_pkg::LIMIT_RESET); end
      endcase
      for (int k = 0; k < n_items; k++) begin
        send(random_word(reg_pct, unreg_pct), 1'b0, '0);
        if (k == n_items - 1) start <= 1'b0;
        else idle_gap(gaps_on);
      end
      drain();
    end

    // Wait out the last results, then keep watching for stray pulses.
    waited = 0;
    while (pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * MAX_ENTRIES + 8) @(posedge clk);
    if (pending.size() != 0) begin
      complain("results never arrived (count)", 32'd0, 32'(pending.size()));
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
